>>> sv/rbi_pkg.sv
// Shared constants and types for the range/bearing innovation unit.
// No dependencies; imported by rbi_regs, the top level and the checker.
`default_nettype none

package rbi_pkg;

    localparam int FRAC_BITS = 16;

    // APB register map: four 32-bit words
    localparam int ADDR_W = 4;

    typedef enum logic [1:0] {
        REG_NOISE_00,
        REG_NOISE_01,
        REG_NOISE_10,
        REG_NOISE_11
    } t_reg_idx;

    // measurement noise R, indexed row*2+col
    typedef logic [3:0][31:0] t_noise;

    // angles in Q30 and in output fixed point
    localparam longint PI_Q30     = 64'sd3373259426;
    localparam longint TWO_PI_Q30 = 64'sd6746518853;
    localparam longint PI_F    = (PI_Q30 + (64'sd1 << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    localparam longint TWO_PI_F =
        (TWO_PI_Q30 + (64'sd1 << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    // reciprocal of 2*pi scaled by 2^50, rounded up
    localparam int     RECIP_SH = 50;
    localparam longint RECIP_2PI = (64'sd1 <<< RECIP_SH) / TWO_PI_F + 64'sd1;

    localparam int CORDIC_STEPS = 31;

    function automatic logic signed [35:0] atan_q30(input int i);
        case (i)
            0:  atan_q30 = 36'sd843314856;
            1:  atan_q30 = 36'sd497837829;
            2:  atan_q30 = 36'sd263043836;
            3:  atan_q30 = 36'sd133525158;
            4:  atan_q30 = 36'sd67021686;
            5:  atan_q30 = 36'sd33543515;
            6:  atan_q30 = 36'sd16775850;
            7:  atan_q30 = 36'sd8388437;
            8:  atan_q30 = 36'sd4194282;
            9:  atan_q30 = 36'sd2097149;
            10: atan_q30 = 36'sd1048575;
            11: atan_q30 = 36'sd524287;
            12: atan_q30 = 36'sd262143;
            13: atan_q30 = 36'sd131071;
            14: atan_q30 = 36'sd65535;
            15: atan_q30 = 36'sd32767;
            16: atan_q30 = 36'sd16383;
            17: atan_q30 = 36'sd8191;
            18: atan_q30 = 36'sd4095;
            19: atan_q30 = 36'sd2047;
            20: atan_q30 = 36'sd1023;
            21: atan_q30 = 36'sd511;
            22: atan_q30 = 36'sd255;
            23: atan_q30 = 36'sd127;
            24: atan_q30 = 36'sd63;
            25: atan_q30 = 36'sd31;
            26: atan_q30 = 36'sd15;
            27: atan_q30 = 36'sd8;
            28: atan_q30 = 36'sd4;
            29: atan_q30 = 36'sd2;
            30: atan_q30 = 36'sd1;
            default: atan_q30 = '0;
        endcase
    endfunction

endpackage

`default_nettype wire

>>> sv/rbi_regs.sv
// APB configuration registers: measurement noise matrix R.
// Depends on rbi_pkg.
`default_nettype none

module rbi_regs import rbi_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output t_noise            o_noise
);

    t_noise   r_noise;
    t_reg_idx w_idx;

    assign w_idx   = t_reg_idx'(paddr[3:2]);
    assign pready  = 1'b1;
    assign o_noise = r_noise;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_noise <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                REG_NOISE_00: r_noise[0] <= pwdata;
                REG_NOISE_01: r_noise[1] <= pwdata;
                REG_NOISE_10: r_noise[2] <= pwdata;
                REG_NOISE_11: r_noise[3] <= pwdata;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_NOISE_00: prdata = r_noise[0];
            REG_NOISE_01: prdata = r_noise[1];
            REG_NOISE_10: prdata = r_noise[2];
            REG_NOISE_11: prdata = r_noise[3];
        endcase
    end

endmodule

`default_nettype wire

>>> sv/range_bearing_innovation_unit.sv
// Throughput: one transaction per cycle; the pipeline advances whenever the
// output stage is empty or being taken, and stalls as a whole otherwise.
// Depth is set by the 33-step square root followed by the 33-step divider.
// Reset (synchronous, active low) clears all stage valid bits and the R registers.
`default_nettype none

module range_bearing_innovation_unit import rbi_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic signed [31:0]  i_robot_x,
    input  logic signed [31:0]  i_robot_y,
    input  logic signed [31:0]  i_robot_heading,
    input  logic signed [31:0]  i_landmark_x,
    input  logic signed [31:0]  i_landmark_y,
    input  logic signed [31:0]  i_lmcov_00,
    input  logic signed [31:0]  i_lmcov_01,
    input  logic signed [31:0]  i_lmcov_10,
    input  logic signed [31:0]  i_lmcov_11,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [31:0]         o_expected_range,
    output logic signed [18:0]  o_expected_bearing,
    output logic signed [17:0]  o_unit_dx,
    output logic signed [17:0]  o_unit_dy,
    output logic signed [31:0]  o_dy_over_sq,
    output logic signed [31:0]  o_dx_over_sq,
    output logic signed [31:0]  o_innov_00,
    output logic signed [31:0]  o_innov_01,
    output logic signed [31:0]  o_innov_10,
    output logic signed [31:0]  o_innov_11,
    output logic                o_degenerate,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    // stage schedule
    localparam int ST_ABS   = 1;
    localparam int ST_SQR   = 2;
    localparam int ST_SUM   = 3;
    localparam int SQ0      = 4;
    localparam int SQ_LAST  = SQ0 + 32;
    localparam int CO0      = 4;
    localparam int CO_LAST  = CO0 + CORDIC_STEPS - 1;
    localparam int BR0      = CO_LAST + 1;
    localparam int DV0      = SQ_LAST + 1;
    localparam int UD_STEPS = FRAC_BITS + 1;
    localparam int QD_STEPS = 2 * FRAC_BITS + 1;
    localparam int DV_LAST  = DV0 + QD_STEPS - 1;
    localparam int ST_SGN   = DV_LAST + 1;
    localparam int ST_MUL1  = ST_SGN + 1;
    localparam int ST_T     = ST_MUL1 + 1;
    localparam int ST_MUL2  = ST_T + 1;
    localparam int ST_S     = ST_MUL2 + 1;
    localparam int NST      = ST_S + 1;

    localparam logic signed [35:0] PI36   = 36'(PI_Q30);
    localparam logic signed [35:0] RND36  = 36'sd1 <<< (29 - FRAC_BITS);
    localparam logic signed [34:0] PI_F35 = 35'(PI_F);
    localparam logic signed [34:0] TP_F35 = 35'(TWO_PI_F);
    localparam logic signed [67:0] RECIP68 = 68'(RECIP_2PI);

    typedef struct packed {
        logic                  deg;
        logic signed [32:0]    dx, dy;
        logic signed [31:0]    hd;
        logic [3:0][31:0]      p;
        logic [32:0]           a, b;
        logic [5:0]            shf;
        logic [64:0]           a2, b2;
        logic [65:0]           q;
        logic [32:0]           rt;
        logic [35:0]           rm;
        logic signed [45:0]    cx, cy;
        logic signed [35:0]    cz;
        logic signed [34:0]    bt;
        logic signed [67:0]    bp;
        logic signed [18:0]    theta;
        logic [32:0]           r1, r2;
        logic [UD_STEPS-1:0]   q1, q2;
        logic [65:0]           r3, r4;
        logic [QD_STEPS-1:0]   q3, q4;
        logic signed [17:0]    h00, h01;
        logic signed [31:0]    dyq, dxq;
        logic [7:0][64:0]      pr;
        logic [3:0][31:0]      tm;
        logic [3:0][31:0]      sm;
    } t_stage;

    typedef struct packed {
        logic [32:0] rt;
        logic [35:0] rm;
    } t_sqrt;

    typedef struct packed {
        logic signed [45:0] x, y;
        logic signed [35:0] z;
    } t_cordic;

    function automatic t_sqrt sqrt_step(input logic [32:0] rt, input logic [35:0] rm,
                                        input logic [1:0] pair);
        t_sqrt       o;
        logic [35:0] r;
        logic [35:0] tst;
        r   = {rm[33:0], pair};
        tst = {1'b0, rt, 2'b01};
        if (r >= tst) begin
            o.rm = r - tst;
            o.rt = {rt[31:0], 1'b1};
        end else begin
            o.rm = r;
            o.rt = {rt[31:0], 1'b0};
        end
        return o;
    endfunction

    function automatic t_cordic cordic_step(input logic signed [45:0] x,
                                            input logic signed [45:0] y,
                                            input logic signed [35:0] z, input int i);
        t_cordic            o;
        logic signed [45:0] xs;
        logic signed [45:0] ys;
        xs = x >>> i;
        ys = y >>> i;
        if (!y[45]) begin
            o.x = x + ys;
            o.y = y - xs;
            o.z = z + atan_q30(i);
        end else begin
            o.x = x - ys;
            o.y = y + xs;
            o.z = z - atan_q30(i);
        end
        return o;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [66:0] v);
        if (v > 67'sd2147483647)
            return 32'h7FFF_FFFF;
        else if (v < -67'sd2147483648)
            return 32'h8000_0000;
        else
            return v[31:0];
    endfunction

    t_noise           w_noise;
    t_stage           r_st [NST];
    t_stage           n_st [NST];
    logic [NST-1:0]   r_vld;
    logic             w_en;
    t_stage           w_fin;

    rbi_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_noise (w_noise)
    );

    assign w_en       = !r_vld[NST-1] || i_out_ready;
    assign o_in_ready = w_en;

    always_comb begin
        n_st[0]      = '0;
        n_st[0].dx   = 33'(i_landmark_x) - 33'(i_robot_x);
        n_st[0].dy   = 33'(i_landmark_y) - 33'(i_robot_y);
        n_st[0].hd   = i_robot_heading;
        n_st[0].p[0] = i_lmcov_00;
        n_st[0].p[1] = i_lmcov_01;
        n_st[0].p[2] = i_lmcov_10;
        n_st[0].p[3] = i_lmcov_11;
    end

    for (genvar k = 1; k < NST; k++) begin : g_stage
        localparam int SI = (k >= SQ0 && k <= SQ_LAST) ? 32 - (k - SQ0) : 0;
        localparam int CI = (k >= CO0 && k <= CO_LAST) ? k - CO0 : 0;
        localparam int DJ = (k >= DV0 && k <= DV_LAST) ? k - DV0 : 0;

        always_comb begin
            t_stage             r;
            t_stage             n;
            t_sqrt              sq;
            t_cordic            co;
            logic [32:0]        m;
            logic [5:0]         msb;
            logic [64:0]        ea;
            logic [64:0]        eb;
            logic signed [35:0] fz;
            logic signed [17:0] kest;
            logic signed [34:0] bc;
            logic [33:0]        r34;
            logic [66:0]        r67;
            logic signed [66:0] acc;
            logic signed [32:0] hm [4];

            r = r_st[k-1];
            n = r;

            hm[0] = 33'(r.h00);
            hm[1] = 33'(r.h01);
            hm[2] = -33'(r.dyq);
            hm[3] = 33'(r.dxq);

            if (k == ST_ABS) begin
                n.deg = (r.dx == '0) && (r.dy == '0);
                n.a   = r.dx[32] ? 33'(-r.dx) : 33'(r.dx);
                n.b   = r.dy[32] ? 33'(-r.dy) : 33'(r.dy);
                m     = (n.a > n.b) ? n.a : n.b;
                msb   = '0;
                for (int i = 0; i < 33; i++)
                    if (m[i]) msb = 6'(i);
                // normalize so the larger magnitude reaches bit 40
                n.shf = 6'd40 - msb;
            end

            if (k == ST_SQR) begin
                ea   = {32'b0, r.a};
                eb   = {32'b0, r.b};
                n.a2 = ea * ea;
                n.b2 = eb * eb;
                n.cx = 46'(r.dx) <<< r.shf;
                n.cy = 46'(r.dy) <<< r.shf;
            end

            if (k == ST_SUM) begin
                n.q  = {1'b0, r.a2} + {1'b0, r.b2};
                n.rt = '0;
                n.rm = '0;
                // left half plane: rotate by pi first
                if (r.cx[45]) begin
                    n.cz = r.cy[45] ? -PI36 : PI36;
                    n.cx = -r.cx;
                    n.cy = -r.cy;
                end else begin
                    n.cz = '0;
                end
            end

            if (k >= SQ0 && k <= SQ_LAST) begin
                sq   = sqrt_step(r.rt, r.rm, r.q[2*SI+1 -: 2]);
                n.rt = sq.rt;
                n.rm = sq.rm;
            end

            if (k >= CO0 && k <= CO_LAST) begin
                co   = cordic_step(r.cx, r.cy, r.cz, CI);
                n.cx = co.x;
                n.cy = co.y;
                n.cz = co.z;
            end

            // bearing wrap: theta - 2pi*floor((theta+pi)/2pi) via reciprocal
            if (k == BR0) begin
                fz   = (r.cz + RND36) >>> (30 - FRAC_BITS);
                n.bt = 35'(fz) - 35'(r.hd) + PI_F35;
            end
            if (k == BR0 + 1) begin
                n.bp = 68'(r.bt) * RECIP68;
            end
            if (k == BR0 + 2) begin
                kest = r.bp[67:RECIP_SH];
                n.bt = r.bt - 35'(kest) * TP_F35;
            end
            if (k == BR0 + 3) begin
                if (r.bt[34])
                    bc = r.bt + TP_F35;
                else if (r.bt >= TP_F35)
                    bc = r.bt - TP_F35;
                else
                    bc = r.bt;
                n.theta = 19'(bc - PI_F35);
            end

            // restoring dividers: |dx|,|dy| << FRAC_BITS by d
            if (k >= DV0 && k < DV0 + UD_STEPS) begin
                r34 = (DJ == 0) ? {1'b0, r.a} : {r.r1, 1'b0};
                if (r34 >= {1'b0, r.rt}) begin
                    n.r1 = 33'(r34 - {1'b0, r.rt});
                    n.q1 = {r.q1[UD_STEPS-2:0], 1'b1};
                end else begin
                    n.r1 = r34[32:0];
                    n.q1 = {r.q1[UD_STEPS-2:0], 1'b0};
                end
                r34 = (DJ == 0) ? {1'b0, r.b} : {r.r2, 1'b0};
                if (r34 >= {1'b0, r.rt}) begin
                    n.r2 = 33'(r34 - {1'b0, r.rt});
                    n.q2 = {r.q2[UD_STEPS-2:0], 1'b1};
                end else begin
                    n.r2 = r34[32:0];
                    n.q2 = {r.q2[UD_STEPS-2:0], 1'b0};
                end
            end

            // |dy|,|dx| << 2*FRAC_BITS by q
            if (k >= DV0 && k <= DV_LAST) begin
                r67 = (DJ == 0) ? {34'b0, r.b} : {r.r3, 1'b0};
                if (r67 >= {1'b0, r.q}) begin
                    n.r3 = 66'(r67 - {1'b0, r.q});
                    n.q3 = {r.q3[QD_STEPS-2:0], 1'b1};
                end else begin
                    n.r3 = r67[65:0];
                    n.q3 = {r.q3[QD_STEPS-2:0], 1'b0};
                end
                r67 = (DJ == 0) ? {34'b0, r.a} : {r.r4, 1'b0};
                if (r67 >= {1'b0, r.q}) begin
                    n.r4 = 66'(r67 - {1'b0, r.q});
                    n.q4 = {r.q4[QD_STEPS-2:0], 1'b1};
                end else begin
                    n.r4 = r67[65:0];
                    n.q4 = {r.q4[QD_STEPS-2:0], 1'b0};
                end
            end

            if (k == ST_SGN) begin
                n.h00 = r.dx[32] ? -18'(r.q1) : 18'(r.q1);
                n.h01 = r.dy[32] ? -18'(r.q2) : 18'(r.q2);
                if (!r.dy[32])
                    n.dyq = (r.q3 > 33'h07FFF_FFFF) ? 32'h7FFF_FFFF : r.q3[31:0];
                else
                    n.dyq = (r.q3 >= 33'h08000_0000) ? 32'h8000_0000 : 32'(-r.q3[31:0]);
                if (!r.dx[32])
                    n.dxq = (r.q4 > 33'h07FFF_FFFF) ? 32'h7FFF_FFFF : r.q4[31:0];
                else
                    n.dxq = (r.q4 >= 33'h08000_0000) ? 32'h8000_0000 : 32'(-r.q4[31:0]);
            end

            // T = Hl * P
            if (k == ST_MUL1) begin
                for (int i = 0; i < 2; i++) begin
                    for (int j = 0; j < 2; j++) begin
                        n.pr[(i*2+j)*2]   = hm[i*2]   * $signed(r.p[j]);
                        n.pr[(i*2+j)*2+1] = hm[i*2+1] * $signed(r.p[2+j]);
                    end
                end
            end
            if (k == ST_T) begin
                for (int e = 0; e < 4; e++) begin
                    acc     = ($signed(r.pr[e*2]) >>> FRAC_BITS)
                            + ($signed(r.pr[e*2+1]) >>> FRAC_BITS);
                    n.tm[e] = sat32(acc);
                end
            end

            // S = T * Hl' + R
            if (k == ST_MUL2) begin
                for (int i = 0; i < 2; i++) begin
                    for (int j = 0; j < 2; j++) begin
                        n.pr[(i*2+j)*2]   = $signed(r.tm[i*2])   * hm[j*2];
                        n.pr[(i*2+j)*2+1] = $signed(r.tm[i*2+1]) * hm[j*2+1];
                    end
                end
            end
            if (k == ST_S) begin
                for (int e = 0; e < 4; e++) begin
                    acc     = ($signed(r.pr[e*2]) >>> FRAC_BITS)
                            + ($signed(r.pr[e*2+1]) >>> FRAC_BITS)
                            + $signed(w_noise[e]);
                    n.sm[e] = sat32(acc);
                end
            end

            n_st[k] = n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NST-2:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < NST; k++)
                r_st[k] <= n_st[k];
        end
    end

    assign w_fin       = r_st[NST-1];
    assign o_out_valid = r_vld[NST-1];

    always_comb begin
        o_degenerate = w_fin.deg;
        if (w_fin.deg) begin
            o_expected_range   = '0;
            o_expected_bearing = '0;
            o_unit_dx          = '0;
            o_unit_dy          = '0;
            o_dy_over_sq       = '0;
            o_dx_over_sq       = '0;
            o_innov_00         = '0;
            o_innov_01         = '0;
            o_innov_10         = '0;
            o_innov_11         = '0;
        end else begin
            o_expected_range   = w_fin.rt[32] ? 32'hFFFF_FFFF : w_fin.rt[31:0];
            o_expected_bearing = w_fin.theta;
            o_unit_dx          = w_fin.h00;
            o_unit_dy          = w_fin.h01;
            o_dy_over_sq       = w_fin.dyq;
            o_dx_over_sq       = w_fin.dxq;
            o_innov_00         = w_fin.sm[0];
            o_innov_01         = w_fin.sm[1];
            o_innov_10         = w_fin.sm[2];
            o_innov_11         = w_fin.sm[3];
        end
    end

endmodule

`default_nettype wire

>>> sv/rbi_checker.sv
// Port-level checks for range_bearing_innovation_unit, attached by bind.
// Depends on rbi_pkg.
`default_nettype none

module rbi_checker import rbi_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input logic [31:0]         o_expected_range,
    input logic signed [18:0]  o_expected_bearing,
    input logic signed [17:0]  o_unit_dx,
    input logic signed [17:0]  o_unit_dy,
    input logic signed [31:0]  o_innov_00,
    input logic signed [31:0]  o_dx_over_sq,
    input logic                o_degenerate
);

    // an empty output stage never blocks the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input blocked with empty output stage");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_expected_range)
            && $stable(o_expected_bearing) && $stable(o_innov_00))
        else $error("result changed while stalled");

    a_degenerate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_degenerate |-> o_expected_range == '0 && o_unit_dx == '0
            && o_innov_00 == '0 && o_dx_over_sq == '0)
        else $error("degenerate result not zeroed");

    a_bearing_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_expected_bearing >= -19'sd205887
            && o_expected_bearing <= 19'sd205887)
        else $error("bearing outside wrap range");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_unit_dx >= -18'sd65536 && o_unit_dx <= 18'sd65536
            && o_unit_dy >= -18'sd65536 && o_unit_dy <= 18'sd65536)
        else $error("unit vector term out of range");

endmodule

bind range_bearing_innovation_unit rbi_checker u_rbi_checker (.*);

`default_nettype wire
